[rtl/pba_pkg.sv]
// ----------------------------------------------------------------------------
// pba_pkg
// Types and constants shared by the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  typedef struct packed {
    logic        kind;
    logic [31:0] size_bytes;
    logic [31:0] base_address;
  } pba_req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
  } pba_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_DONE
  } pba_state_e;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_NO_RUN   = 2'd1;
  localparam logic [1:0] STATUS_REJECTED = 2'd2;

  localparam logic REG_POOL_FIRST = 1'b0;
  localparam logic REG_POOL_COUNT = 1'b1;

  localparam int CFG_BITS   = 13;
  localparam int SCAN_LANES = 8;

endpackage

[rtl/page_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// First-fit page allocator over a used-page bitmap held in one RAM.
//
// Request channel (req_valid_i/req_ready_o/req_i): allocate or free a byte
// range. Response channel (rsp_valid_o/rsp_ready_i/rsp_o): one transaction
// per request, in order, with granted address and status.
// Pool bounds are set over the APB port (pool_first_page at 0x0,
// pool_page_count at 0x4); write them only while the block is idle.
// After reset the bitmap RAM is cleared one word per cycle, all MAP_WORDS
// words, with req_ready_o low; APB writes are taken throughout.
// One request at a time. An allocate scans up to 8 pages a cycle within a
// map word, reading each map word before it is scanned. The pages of a run
// that is found, or of a free, are then set or cleared by a read-modify-
// write of each covered word in the bitmap RAM.
// A response waiting on rsp_ready_i holds in the output register; the
// next request is accepted meanwhile and its result waits behind it.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
  parameter int MAP_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12,
  parameter int WORD_BITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  pba_pkg::pba_req_t    req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output pba_pkg::pba_rsp_t    rsp_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import pba_pkg::*;

  localparam int MAP_WORDS = (MAP_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int PW0       = $clog2(MAP_PAGES + 1);
  localparam int PW        = (PW0 > BW + 1) ? PW0 : BW + 1;
  localparam int NW        = 33 - PAGE_SHIFT;
  localparam int SW        = 32 - PAGE_SHIFT;
  localparam int DS        = PW + BW;
  localparam int RW        = PW + 1;
  localparam int PRW       = PW + RW;
  localparam int RECIP     = (2 ** DS) / WORD_BITS;

  localparam logic [RW-1:0]   RECIP_C  = RW'(RECIP);
  localparam logic [PW:0]     MAP_C    = (PW + 1)'(MAP_PAGES);
  localparam logic [PW:0]     WORD_C   = (PW + 1)'(WORD_BITS);
  localparam logic [BW:0]     WORD_B   = (BW + 1)'(WORD_BITS);
  localparam logic [AW-1:0]   LAST_W   = AW'(MAP_WORDS - 1);
  localparam logic [32:0]     PMASK    = 33'((2 ** PAGE_SHIFT) - 1);

  pba_state_e state_q, state_d;

  logic [CFG_BITS-1:0] first_q, first_d;
  logic [CFG_BITS-1:0] count_q, count_d;

  logic          op_q, op_d;
  logic          upd_q, upd_d;
  logic [NW-1:0] need_q, need_d;
  logic [PW-1:0] p_q, p_d;
  logic [PW-1:0] lim_q, lim_d;
  logic [PW-1:0] start_q, start_d;
  logic [NW-1:0] run_q, run_d;
  logic [AW-1:0] widx_q, widx_d;
  logic [BW-1:0] boff_q, boff_d;
  logic [PW-1:0] wbase_q, wbase_d;
  logic [PRW-1:0] prod_q, prod_d;
  pba_rsp_t      res_q, res_d;
  pba_rsp_t      rsp_q, rsp_d;
  logic          rsp_valid_q, rsp_valid_d;

  logic                 mem_we, mem_re;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (widx_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (widx_q),
    .rdata_o (mem_rdata)
  );

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POOL_COUNT) ? 32'(count_q) : 32'(first_q);

  always_comb begin
    first_d = first_q;
    count_d = count_q;
    if (psel && penable && pwrite) begin
      if (paddr[2] == REG_POOL_FIRST) begin
        first_d = pwdata[CFG_BITS-1:0];
      end else begin
        count_d = pwdata[CFG_BITS-1:0];
      end
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    logic [32:0]          need_sum;
    logic [NW-1:0]        need_in;
    logic [PW+1:0]        pool_end;
    logic [PW+1:0]        pool_lim;
    logic [SW-1:0]        fpage;
    logic [33:0]          fend;
    logic [PW-1:0]        qe;
    logic [PW-1:0]        qw;
    logic [PW-1:0]        rem;
    logic [PW-1:0]        rem_l;
    logic [BW:0]          rem_w;
    logic [PW-1:0]        adv;
    logic [WORD_BITS-1:0] word_sh;
    logic [NW-1:0]        run;
    logic [PW-1:0]        st;
    logic                 hit;
    logic [PW-1:0]        p_n;
    logic [BW:0]          boff_n;
    logic [WORD_BITS-1:0] mask;
    logic [PW:0]          pg;
    logic                 last_word;

    state_d     = state_q;
    op_d        = op_q;
    upd_d       = upd_q;
    need_d      = need_q;
    p_d         = p_q;
    lim_d       = lim_q;
    start_d     = start_q;
    run_d       = run_q;
    widx_d      = widx_q;
    boff_d      = boff_q;
    wbase_d     = wbase_q;
    prod_d      = prod_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = '0;

    need_sum = {1'b0, req_i.size_bytes} + PMASK;
    need_in  = need_sum[32:PAGE_SHIFT];
    pool_end = (PW + 2)'(first_q) + (PW + 2)'(count_q);
    pool_lim = (pool_end > (PW + 2)'(MAP_PAGES)) ? (PW + 2)'(MAP_PAGES) : pool_end;
    fpage    = req_i.base_address[31:PAGE_SHIFT];
    fend     = 34'(fpage) + 34'(need_in);

    qe  = PW'(prod_q >> DS);
    qw  = PW'(qe * WORD_BITS);
    rem = p_q - qw;

    rem_w   = WORD_B - {1'b0, boff_q};
    rem_l   = lim_q - p_q;
    adv     = PW'(SCAN_LANES);
    if (PW'(rem_w) < adv) begin
      adv = PW'(rem_w);
    end
    if (rem_l < adv) begin
      adv = rem_l;
    end
    word_sh = mem_rdata >> boff_q;
    run     = run_q;
    st      = start_q;
    hit     = 1'b0;
    for (int k = 0; k < SCAN_LANES; k++) begin
      if ((PW'(k) < adv) && !hit) begin
        if (!word_sh[k]) begin
          if (run == '0) begin
            st = p_q + PW'(k);
          end
          run = run + NW'(1);
          if (run == need_q) begin
            hit = 1'b1;
          end
        end else begin
          run = '0;
        end
      end
    end
    p_n    = p_q + adv;
    boff_n = {1'b0, boff_q} + (BW + 1)'(adv);

    for (int j = 0; j < WORD_BITS; j++) begin
      pg      = {1'b0, wbase_q} + (PW + 1)'(j);
      mask[j] = (pg >= {1'b0, p_q}) && (pg < {1'b0, lim_q});
    end
    last_word = ({1'b0, wbase_q} + WORD_C) >= {1'b0, lim_q};

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (widx_q == LAST_W) begin
          widx_d  = '0;
          state_d = ST_IDLE;
        end else begin
          widx_d = widx_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d   = req_i.kind;
          need_d = need_in;
          res_d  = '{granted_address: '0, status: STATUS_DONE};
          if (req_i.size_bytes == '0) begin
            res_d.status = STATUS_REJECTED;
            state_d      = ST_DONE;
          end else if (req_i.kind == KIND_ALLOC) begin
            upd_d   = 1'b0;
            run_d   = '0;
            p_d     = PW'(first_q);
            lim_d   = PW'(pool_lim);
            if ((PW + 2)'(first_q) >= pool_lim) begin
              res_d.status = STATUS_NO_RUN;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_DIV_MUL;
            end
          end else begin
            upd_d = 1'b1;
            p_d   = PW'(fpage);
            lim_d = (fend > 34'(MAP_PAGES)) ? PW'(MAP_PAGES) : PW'(fend);
            if (req_i.base_address[PAGE_SHIFT-1:0] != '0) begin
              res_d.status = STATUS_REJECTED;
              state_d      = ST_DONE;
            end else if (33'(fpage) >= 33'(MAP_C)) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_DIV_MUL;
            end
          end
        end
      end
      ST_DIV_MUL: begin
        prod_d  = PRW'(p_q) * PRW'(RECIP_C);
        state_d = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        if (rem >= PW'(WORD_BITS)) begin
          widx_d  = AW'(qe + PW'(1));
          boff_d  = BW'(rem - PW'(WORD_BITS));
          wbase_d = p_q - (rem - PW'(WORD_BITS));
        end else begin
          widx_d  = AW'(qe);
          boff_d  = BW'(rem);
          wbase_d = p_q - rem;
        end
        state_d = upd_q ? ST_UPD_RD : ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        mem_re  = 1'b1;
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        run_d   = run;
        start_d = st;
        if (hit) begin
          upd_d   = 1'b1;
          p_d     = st;
          lim_d   = st + PW'(need_q);
          state_d = ST_DIV_MUL;
        end else if (p_n >= lim_q) begin
          res_d.status = STATUS_NO_RUN;
          state_d      = ST_DONE;
        end else begin
          p_d = p_n;
          if (boff_n == WORD_B) begin
            boff_d  = '0;
            widx_d  = widx_q + AW'(1);
            state_d = ST_SCAN_RD;
          end else begin
            boff_d = BW'(boff_n);
          end
        end
      end
      ST_UPD_RD: begin
        mem_re  = 1'b1;
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (op_q == KIND_ALLOC) ? (mem_rdata | mask) : (mem_rdata & ~mask);
        if (last_word) begin
          if (op_q == KIND_ALLOC) begin
            res_d.granted_address = 32'(start_q) << PAGE_SHIFT;
          end
          state_d = ST_DONE;
        end else begin
          widx_d  = widx_q + AW'(1);
          wbase_d = wbase_q + PW'(WORD_BITS);
          state_d = ST_UPD_RD;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_d       = res_q;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      first_q     <= '0;
      count_q     <= '0;
      widx_q      <= '0;
      rsp_valid_q <= 1'b0;
      op_q        <= KIND_ALLOC;
      upd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      count_q     <= count_d;
      widx_q      <= widx_d;
      rsp_valid_q <= rsp_valid_d;
      op_q        <= op_d;
      upd_q       <= upd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q  <= need_d;
    p_q     <= p_d;
    lim_q   <= lim_d;
    start_q <= start_d;
    run_q   <= run_d;
    boff_q  <= boff_d;
    wbase_q <= wbase_d;
    prod_q  <= prod_d;
    res_q   <= res_d;
    rsp_q   <= rsp_d;
  end

endmodule

[rtl/pba_ram.sv]
// ----------------------------------------------------------------------------
// pba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
